>>> src/ebl_pkg.sv
// Package with the shared types and constants of the error blink code LED block.
package ebl_pkg;

    localparam int CODE_W = 16;
    localparam int STEP_W = 5;
    localparam int IDX_W  = 2;

    // Fast blink: four ticks per period, lit for the first two.
    localparam logic [STEP_W-1:0] FAST_PERIOD = 5'd4;
    localparam logic [STEP_W-1:0] ON_TICKS    = 5'd2;

    // Heartbeat toggle points, where the step is a multiple of ten.
    localparam logic [STEP_W-1:0] TOGGLE_0 = 5'd0;
    localparam logic [STEP_W-1:0] TOGGLE_1 = 5'd10;
    localparam logic [STEP_W-1:0] TOGGLE_2 = 5'd20;
    localparam logic [STEP_W-1:0] TOGGLE_3 = 5'd30;

    localparam logic [CODE_W-1:0] ONE_BLINK_RESET   = 16'd1;
    localparam logic [CODE_W-1:0] TWO_BLINK_RESET   = 16'd2;
    localparam logic [CODE_W-1:0] THREE_BLINK_RESET = 16'd4;

    typedef enum logic [IDX_W-1:0] {
        REG_ONE_BLINK   = 2'd0,
        REG_TWO_BLINK   = 2'd1,
        REG_THREE_BLINK = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [CODE_W-1:0] one_blink_code;
        logic [CODE_W-1:0] two_blink_code;
        logic [CODE_W-1:0] three_blink_code;
    } blink_codes_t;

endpackage

>>> src/ebl_cfg.sv
// Configuration registers holding the three blink codes.
module ebl_cfg
    import ebl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CODE_W-1:0]   cfg_data,
    output blink_codes_t        codes
);

    blink_codes_t codes_reg;
    blink_codes_t codes_next;

    assign cfg_ready = 1'b1;
    assign codes     = codes_reg;

    always_comb begin
        codes_next = codes_reg;
        if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_ONE_BLINK:   codes_next.one_blink_code   = cfg_data;
                REG_TWO_BLINK:   codes_next.two_blink_code   = cfg_data;
                REG_THREE_BLINK: codes_next.three_blink_code = cfg_data;
                default:         codes_next = codes_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg.one_blink_code   <= ONE_BLINK_RESET;
            codes_reg.two_blink_code   <= TWO_BLINK_RESET;
            codes_reg.three_blink_code <= THREE_BLINK_RESET;
        end else begin
            codes_reg <= codes_next;
        end
    end

endmodule

>>> src/ebl_core.sv
// Pattern state update and two-entry output buffer of the blink code LED block.
module ebl_core
    import ebl_pkg::*;
#(
    parameter int FRAME_TICKS      = 30,
    parameter int HEARTBEAT_PERIOD = 20
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  blink_codes_t        codes,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CODE_W-1:0]   error_word,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                led_on
);

    localparam logic [STEP_W:0] FRAME_WRAP = (STEP_W+1)'(FRAME_TICKS);
    localparam logic [STEP_W:0] HEART_WRAP = (STEP_W+1)'(HEARTBEAT_PERIOD);
    localparam logic [STEP_W:0] FAST_WRAP  = {1'b0, FAST_PERIOD};

    logic [STEP_W-1:0] step_reg,   step_next;
    logic              level_reg,  level_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_led_reg,   out_led_next;
    logic              skid_valid_reg, skid_valid_next;
    logic              skid_led_reg,   skid_led_next;

    logic              push;
    logic              pop;
    logic              is_zero;
    logic              is_single;
    logic [1:0]        blinks;
    logic              toggle_point;
    logic              fast_lit;
    logic [STEP_W-1:0] blink_limit;
    logic [STEP_W:0]   step_inc;
    logic [STEP_W:0]   wrap_at;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign led_on    = out_led_reg;

    assign is_zero   = (error_word == '0);
    assign is_single = !is_zero && ((error_word & (error_word - 1'b1)) == '0);

    // First match wins, in register order.
    always_comb begin
        if (error_word == codes.one_blink_code) begin
            blinks = 2'd1;
        end else if (error_word == codes.two_blink_code) begin
            blinks = 2'd2;
        end else if (error_word == codes.three_blink_code) begin
            blinks = 2'd3;
        end else begin
            blinks = 2'd0;
        end
    end

    assign toggle_point = (step_reg == TOGGLE_0) || (step_reg == TOGGLE_1) ||
                          (step_reg == TOGGLE_2) || (step_reg == TOGGLE_3);
    assign fast_lit     = ({3'b000, step_reg[1:0]} < ON_TICKS);
    assign blink_limit  = {1'b0, blinks, 2'b00};
    assign step_inc     = {1'b0, step_reg} + 1'b1;

    always_comb begin
        level_next = level_reg;
        step_next  = step_reg;
        wrap_at    = HEART_WRAP;
        if (is_zero) begin
            wrap_at    = HEART_WRAP;
            level_next = level_reg ^ toggle_point;
            step_next  = (step_inc >= wrap_at) ? '0 : step_inc[STEP_W-1:0];
        end else if (!is_single) begin
            wrap_at    = FAST_WRAP;
            level_next = fast_lit;
            step_next  = (step_inc >= wrap_at) ? '0 : step_inc[STEP_W-1:0];
        end else if (blinks != 2'd0) begin
            wrap_at    = FRAME_WRAP;
            level_next = (step_reg < blink_limit) && fast_lit;
            step_next  = (step_inc >= wrap_at) ? '0 : step_inc[STEP_W-1:0];
        end else begin
            // A single bit that matches no code forces the LED dark.
            level_next = 1'b0;
            step_next  = '0;
        end
    end

    // The skid entry is only filled when the output entry is stalled.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_led_next    = out_led_reg;
        skid_valid_next = skid_valid_reg;
        skid_led_next   = skid_led_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_led_next    = skid_led_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_next = 1'b1;
                out_led_next   = level_next;
            end else begin
                skid_valid_next = 1'b1;
                skid_led_next   = level_next;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= '0;
            level_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (push) begin
                step_reg  <= step_next;
                level_reg <= level_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_led_reg  <= out_led_next;
        skid_led_reg <= skid_led_next;
    end

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a beat while the output entry is empty");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg != 5'd31)
        else $error("step counter left its range");

    a_unmatched_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && is_single && blinks == 2'd0) |=> (step_reg == '0 && level_reg == 1'b0))
        else $error("unmatched single code did not clear the pattern");

    a_pushed_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !out_valid_reg) |=> (out_valid_reg && out_led_reg == level_reg))
        else $error("output beat differs from the new LED level");

endmodule

>>> src/error_blink_code_led_top.sv
// Top level of the error blink code LED block.
// One tick beat on the slave side gives one LED level beat on the master side. A beat is
// taken every clock cycle: the whole pattern update is one level of logic from the state
// registers, and the result lands in a two-entry output buffer, so a new tick is taken
// while a result waits and s_tready drops only when both entries are full. An accepted
// tick's result is registered in the output or, on a stall, the skid entry. Configuration
// writes are always ready and take effect on the next tick; index 3 is ignored.
module error_blink_code_led_top
    import ebl_pkg::*;
#(
    parameter int FRAME_TICKS      = 30,
    parameter int HEARTBEAT_PERIOD = 20
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,     // [15:0] error_word
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,     // [0] led_on, [7:1] zero
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CODE_W-1:0]   cfg_data
);

    blink_codes_t codes;
    logic         led_on;

    ebl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .codes     (codes)
    );

    ebl_core #(
        .FRAME_TICKS      (FRAME_TICKS),
        .HEARTBEAT_PERIOD (HEARTBEAT_PERIOD)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .codes      (codes),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .error_word (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .led_on     (led_on)
    );

    assign m_tdata = {7'b0000000, led_on};

endmodule
